/* sv/rau_pkg.sv */
// Package: shared constants, opcodes and helper types for the rational accumulator.
`default_nettype none
package rau_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IO_WIDTH = 32;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_CMP  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // divider request bundle (start and quotient/remainder select)
    typedef struct packed {
        logic start;
        logic quot;
    } div_ctl_t;
endpackage
`default_nettype wire

/* sv/rau_if.sv */
// Interfaces: valid/ready channels carrying the input and result words.
`default_nettype none
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic signed [31:0] operand_num;
    logic signed [31:0] operand_den;
    modport source (output valid, opcode, operand_num, operand_den, input ready);
    modport sink   (input valid, opcode, operand_num, operand_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic        is_less;
    logic        is_greater;
    logic [1:0]  status;
    modport source (output valid, result_num, result_den, is_less, is_greater, status,
                    input ready);
    modport sink   (input valid, result_num, result_den, is_less, is_greater, status,
                    output ready);
endinterface
`default_nettype wire

/* sv/rational_accumulator_unit_core.sv */
// Top level: rational accumulator with sequenced gcd reduction.
//
// Usage:
//   The block holds one signed fraction num/den, reset to 1/1. An input
//   word (opcode, operand_num, operand_den) is taken on in_ch when valid and
//   ready are both high; exactly one result word follows on out_ch.
//   Load, add, subtract and increment form a new pair (add and subtract from
//   cross-products), then reduce it by a Euclid gcd (truncating remainder, may
//   be negative). Compare leaves the state alone and sets is_less / is_greater.
//   Status: 0 ok, 1 load with zero denominator rejected, 2 wrapped overflow.
// Timing:
//   One item at a time; in_ch.ready is low from accept until the result
//   word leaves. The products are formed in turn on one shared multiplier
//   (one product per cycle, registered). The gcd and both reducing divisions
//   run on one shared bit-serial divider, one remainder or quotient at a
//   time. Add and subtract run the products, the gcd and the divisions;
//   load and increment skip the products. A 0/0 pair skips both divisions.
//   Compare goes to its result word after the products, a rejected load
//   straight from accept. After each result the sequencer returns to idle,
//   where the next word is taken.
// Reset: asynchronous, active low; the state returns to 1/1 and the
//   sequencer to idle. If the receiver stalls, the result word holds on
//   out_ch and no new input is taken until it is taken.
`default_nettype none
module rational_accumulator_unit_core #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    rau_in_if.sink   in_ch,
    rau_out_if.source out_ch
);
    import rau_pkg::*;
    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * W + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_FORM  = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_GWAIT = 4'd6;
    localparam logic [3:0] S_DNUM  = 4'd7;
    localparam logic [3:0] S_WNUM  = 4'd8;
    localparam logic [3:0] S_DDEN  = 4'd9;
    localparam logic [3:0] S_WDEN  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [W-1:0]  held_num_reg, held_num_next;
    logic [W-1:0]  held_den_reg, held_den_next;
    logic [2:0]    op_reg, op_next;
    logic [W-1:0]  c_reg, c_next;
    logic [W-1:0]  d_reg, d_next;
    logic [PW-1:0] pa_reg, pa_next;   // n*d
    logic [PW-1:0] pb_reg, pb_next;   // c*m
    logic [PW-1:0] pc_reg, pc_next;   // m*d
    logic [W-1:0]  nn_reg, nn_next;
    logic [W-1:0]  dd_reg, dd_next;
    logic [W-1:0]  ga_reg, ga_next;
    logic [W-1:0]  gb_reg, gb_next;
    logic          ovf_reg, ovf_next;
    logic          lt_reg, lt_next;
    logic          gt_reg, gt_next;
    logic [1:0]    st_reg, st_next;

    // shared multiplier, one signed product per cycle
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [2*W-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // shared divider on magnitudes
    div_ctl_t      dctl;
    logic [W-1:0]  div_x, div_y, div_res;
    logic          div_done;
    logic          div_xneg, div_yneg;

    rau_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (div_x),
        .divisor  (div_y),
        .done     (div_done),
        .result   (div_res)
    );

    logic [W-1:0]  in_c, in_d;
    logic [PW-1:0] nsum, den_w;
    logic          fit_n, fit_d;
    logic [W-1:0]  rem_s, quo_s;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic fits(input logic [PW-1:0] v);
        fits = (v[PW-1:W-1] == {(PW-W+1){1'b0}}) || (v[PW-1:W-1] == {(PW-W+1){1'b1}});
    endfunction

    assign in_c = W'($signed(in_ch.operand_num));
    assign in_d = W'($signed(in_ch.operand_den));

    // signed results from the magnitude divider
    assign rem_s = div_xneg ? (~div_res + W'(1)) : div_res;
    assign quo_s = (div_xneg != div_yneg) ? (~div_res + W'(1)) : div_res;

    always_comb
    begin
        state_next    = state_reg;
        held_num_next = held_num_reg;
        held_den_next = held_den_reg;
        op_next  = op_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        pa_next  = pa_reg;
        pb_next  = pb_reg;
        pc_next  = pc_reg;
        nn_next  = nn_reg;
        dd_next  = dd_reg;
        ga_next  = ga_reg;
        gb_next  = gb_reg;
        ovf_next = ovf_reg;
        lt_next  = lt_reg;
        gt_next  = gt_reg;
        st_next  = st_reg;
        mul_a    = $signed(held_num_reg);
        mul_b    = $signed(d_reg);
        dctl     = '0;
        div_x    = mag(ga_reg);
        div_y    = mag(gb_reg);
        div_xneg = ga_reg[W-1];
        div_yneg = gb_reg[W-1];
        nsum     = (op_reg == OP_SUB) ? (pa_reg - pb_reg) : (pa_reg + pb_reg);
        den_w    = pc_reg;
        fit_n    = fits(nsum);
        fit_d    = fits(den_w);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next  = in_ch.opcode;
                    c_next   = in_c;
                    d_next   = in_d;
                    lt_next  = 1'b0;
                    gt_next  = 1'b0;
                    st_next  = ST_OK;
                    ovf_next = 1'b0;
                    if (in_ch.opcode == OP_LOAD)
                    begin
                        if (in_d == '0)
                        begin
                            st_next    = ST_ZDEN;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            pa_next    = PW'($signed(in_c));
                            pb_next    = '0;
                            pc_next    = PW'($signed(in_d));
                            state_next = S_FORM;
                        end
                    end
                    else if (in_ch.opcode == OP_INC)
                    begin
                        pa_next    = PW'($signed(held_num_reg));
                        pb_next    = PW'($signed(held_den_reg));
                        pc_next    = PW'($signed(held_den_reg));
                        state_next = S_FORM;
                    end
                    else if (in_ch.opcode == OP_ADD || in_ch.opcode == OP_SUB
                             || in_ch.opcode == OP_CMP)
                        state_next = S_MUL0;
                    else
                        state_next = S_OUT;
                end
            end
            S_MUL0:
            begin
                pa_next    = PW'(mul_p);
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                mul_a      = $signed(c_reg);
                mul_b      = $signed(held_den_reg);
                pb_next    = PW'(mul_p);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_a   = $signed(held_den_reg);
                mul_b   = $signed(d_reg);
                pc_next = PW'(mul_p);
                if (op_reg == OP_CMP)
                begin
                    lt_next    = $signed(pa_reg) < $signed(pb_reg);
                    gt_next    = $signed(pb_reg) < $signed(pa_reg);
                    state_next = S_OUT;
                end
                else
                    state_next = S_FORM;
            end
            S_FORM:
            begin
                ovf_next   = !fit_n || !fit_d;
                nn_next    = nsum[W-1:0];
                dd_next    = den_w[W-1:0];
                ga_next    = nsum[W-1:0];
                gb_next    = den_w[W-1:0];
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (gb_reg == '0)
                begin
                    if (ga_reg == '0)
                    begin
                        held_num_next = nn_reg;
                        held_den_next = dd_reg;
                        st_next       = ovf_reg ? ST_OVF : ST_OK;
                        state_next    = S_OUT;
                    end
                    else
                        state_next = S_DNUM;
                end
                else
                begin
                    dctl.start = 1'b1;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (div_done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = rem_s;
                    state_next = S_GCD;
                end
            end
            S_DNUM:
            begin
                div_x      = mag(nn_reg);
                div_y      = mag(ga_reg);
                dctl.start = 1'b1;
                dctl.quot  = 1'b1;
                state_next = S_WNUM;
            end
            S_WNUM:
            begin
                div_xneg = nn_reg[W-1];
                div_yneg = ga_reg[W-1];
                if (div_done)
                begin
                    nn_next = quo_s;
                    if (div_xneg == div_yneg && div_res[W-1])
                        ovf_next = 1'b1;
                    state_next = S_DDEN;
                end
            end
            S_DDEN:
            begin
                div_x      = mag(dd_reg);
                div_y      = mag(ga_reg);
                dctl.start = 1'b1;
                dctl.quot  = 1'b1;
                state_next = S_WDEN;
            end
            S_WDEN:
            begin
                div_xneg = dd_reg[W-1];
                div_yneg = ga_reg[W-1];
                if (div_done)
                begin
                    held_num_next = nn_reg;
                    held_den_next = quo_s;
                    st_next = (ovf_reg || (div_xneg == div_yneg && div_res[W-1]))
                              ? ST_OVF : ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_num_reg <= W'(1);
            held_den_reg <= W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            held_num_reg <= held_num_next;
            held_den_reg <= held_den_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        pc_reg  <= pc_next;
        nn_reg  <= nn_next;
        dd_reg  <= dd_next;
        ga_reg  <= ga_next;
        gb_reg  <= gb_next;
        ovf_reg <= ovf_next;
        lt_reg  <= lt_next;
        gt_reg  <= gt_next;
        st_reg  <= st_next;
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.result_num  = IO_WIDTH'($signed(held_num_reg));
    assign out_ch.result_den  = IO_WIDTH'($signed(held_den_reg));
    assign out_ch.is_less     = lt_reg;
    assign out_ch.is_greater  = gt_reg;
    assign out_ch.status      = st_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while a result is pending");
    a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.is_less && out_ch.is_greater))
        else $error("compare flags both set");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(held_num_reg) && $stable(held_den_reg))
        else $error("state moved while result stalled");
    a_reject_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == ST_ZDEN |-> $stable(held_num_reg))
        else $error("rejected load changed state");
endmodule
`default_nettype wire

/* sv/rau_div.sv */
// Shared unit: bit-serial unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module rau_div #(
    parameter int W = rau_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire rau_pkg::div_ctl_t ctl,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      result
);
    import rau_pkg::*;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          quot_reg, quot_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quot_next = quot_reg;
        shifted   = {rem_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (ctl.start)
        begin
            rem_next  = '0;
            q_next    = dividend;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            quot_next = ctl.quot;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done   = busy_reg && (cnt_reg == CW'(1)) && !ctl.start;
    assign result = quot_reg ? q_next : rem_next;

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || ctl.start || $past(done))
        else $error("divider count not cleared when idle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("divider done without busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ctl.start |=> !busy_reg)
        else $error("divider still busy after done");
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the rational accumulator: table-driven directed words, then random words.
`timescale 1ns / 1ps
module tb;
    import rau_pkg::*;

    logic clk;
    logic rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_accumulator_unit_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    // One expected result word.
    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               lt;
        logic               gt;
        logic [1:0]         st;
    } frac_res_t;

    // One stimulus word; chk marks rows whose expected word is typed in.
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] c;
        logic signed [31:0] d;
        bit                 chk;
        frac_res_t          res;
    } stim_row_t;

    localparam int MAX_CYCLES = 20000000;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;

    // Predictor copy of the held fraction.
    logic signed [31:0] acc_num = 32'sd1;
    logic signed [31:0] acc_den = 32'sd1;

    // Typed-in expectation that travels with the word being driven.
    bit        drv_chk = 1'b0;
    int        drv_row = 0;
    frac_res_t drv_res;

    frac_res_t pending_q[$];
    int        fail_count = 0;
    int        result_count = 0;
    int        sent_count = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        op_seen[8] = '{default: 0};

    // Clock generation: 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Euclid gcd with truncating remainder; remainder by -1 is 0.
    function automatic logic signed [31:0] trunc_gcd(logic signed [31:0] a,
                                                     logic signed [31:0] b);
        logic signed [31:0] t;
        while (b != 0)
        begin
            if (b == -1)
                t = 0;
            else
                t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Truncating divide at 32 bits; MIN / -1 wraps and flags overflow.
    function automatic logic signed [31:0] trunc_div(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     inout bit ovf);
        if (a == MIN32 && b == -1)
        begin
            ovf = 1'b1;
            return MIN32;
        end
        return a / b;
    endfunction

    // Wrap a wide pair into the held fraction and reduce it; returns overflow.
    function automatic bit reduce_into_acc(logic signed [127:0] n, logic signed [127:0] d);
        bit ovf;
        logic signed [31:0] nn;
        logic signed [31:0] dd;
        logic signed [31:0] g;
        nn  = n[31:0];
        dd  = d[31:0];
        ovf = (128'(nn) != n) || (128'(dd) != d);
        g   = trunc_gcd(nn, dd);
        if (g != 0)
        begin
            nn = trunc_div(nn, g, ovf);
            dd = trunc_div(dd, g, ovf);
        end
        acc_num = nn;
        acc_den = dd;
        return ovf;
    endfunction

    // Predicts the result word of one input word and advances the held fraction.
    function automatic frac_res_t predict_fraction(logic [2:0] op, logic signed [31:0] c,
                                                   logic signed [31:0] d);
        frac_res_t r;
        logic signed [127:0] a;
        logic signed [127:0] b;
        r.lt = 1'b0;
        r.gt = 1'b0;
        r.st = ST_OK;
        a = 128'(acc_num) * 128'(d);
        b = 128'(c) * 128'(acc_den);
        case (op)
            OP_LOAD:
                if (d == 0)
                    r.st = ST_ZDEN;
                else if (reduce_into_acc(128'(c), 128'(d)))
                    r.st = ST_OVF;
            OP_ADD, OP_SUB:
                if (reduce_into_acc(op == OP_ADD ? a + b : a - b,
                                    128'(acc_den) * 128'(d)))
                    r.st = ST_OVF;
            OP_INC:
                if (reduce_into_acc(128'(acc_num) + 128'(acc_den), 128'(acc_den)))
                    r.st = ST_OVF;
            OP_CMP:
            begin
                r.lt = a < b;
                r.gt = a > b;
            end
            default: ;
        endcase
        r.num = acc_num;
        r.den = acc_den;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on result %0d, %s: got %0h, expected %0h",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Random operand: mostly small values so reductions stay busy, some extremes.
    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? MIN32 : MAX32;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
            default: return $signed($urandom_range(0, 40)) - 32'sd20;
        endcase
    endfunction

    // Sends one word; random idle cycles before it per the current phase.
    // Valid stays high after the accepting edge; the caller drops it when done.
    task automatic send_word(logic [2:0] op, logic signed [31:0] c, logic signed [31:0] d);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.operand_num <= c;
        in_ch.operand_den <= d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // Accepted at this edge; the predictor runs in the monitor below.
        sent_count++;
    endtask

    // Input monitor: predicts each accepted word; typed-in rows are checked
    // against the prediction too, which catches a predictor slip.
    always @(posedge clk)
    begin
        frac_res_t p;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            p = predict_fraction(in_ch.opcode, in_ch.operand_num, in_ch.operand_den);
            if (drv_chk && p != drv_res)
            begin
                $display("tb: directed row %0d disagrees with typed-in word", drv_row);
                fail_count++;
            end
            pending_q.push_back(p);
            op_seen[in_ch.opcode]++;
        end
    end

    // Output checker: compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("tb: unexpected result word %0d", result_count);
                fail_count++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (out_ch.result_num !== e.num)
                    report_mismatch("result_num", out_ch.result_num, e.num);
                if (out_ch.result_den !== e.den)
                    report_mismatch("result_den", out_ch.result_den, e.den);
                if (out_ch.is_less !== e.lt)
                    report_mismatch("is_less", 32'(out_ch.is_less), 32'(e.lt));
                if (out_ch.is_greater !== e.gt)
                    report_mismatch("is_greater", 32'(out_ch.is_greater), 32'(e.gt));
                if (out_ch.status !== e.st)
                    report_mismatch("status", 32'(out_ch.status), 32'(e.st));
            end
            result_count++;
        end
    end

    // Receiver backpressure, per phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Watchdog: ends the run at a generous cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Directed table. Typed-in rows: reset state, zero-denominator load, extremes.
    stim_row_t dir_rows[] = '{
        '{OP_CMP,  32'sd1, 32'sd1, 1, '{32'sd1, 32'sd1, 1'b0, 1'b0, ST_OK}},
        '{OP_LOAD, 32'sd5, 32'sd0, 1, '{32'sd1, 32'sd1, 1'b0, 1'b0, ST_ZDEN}},
        '{OP_INC,  32'sd0, 32'sd0, 1, '{32'sd2, 32'sd1, 1'b0, 1'b0, ST_OK}},
        '{OP_LOAD, 32'sd6, -32'sd4, 1, '{32'sd3, -32'sd2, 1'b0, 1'b0, ST_OK}},
        '{OP_LOAD, MIN32, -32'sd1, 1, '{MIN32, 32'sd1, 1'b0, 1'b0, ST_OVF}},
        '{OP_LOAD, MAX32, MAX32, 1, '{32'sd1, 32'sd1, 1'b0, 1'b0, ST_OK}},
        '{OP_LOAD, 32'sd0, 32'sd7, 1, '{32'sd0, 32'sd1, 1'b0, 1'b0, ST_OK}},
        '{OP_ADD,  32'sd3, 32'sd4, 0, '{0, 0, 0, 0, 0}},
        '{OP_SUB,  32'sd3, 32'sd4, 0, '{0, 0, 0, 0, 0}},
        '{OP_ADD,  MAX32, 32'sd1, 0, '{0, 0, 0, 0, 0}},
        '{OP_SUB,  MIN32, MAX32, 0, '{0, 0, 0, 0, 0}},
        '{OP_CMP,  MIN32, 32'sd1, 0, '{0, 0, 0, 0, 0}},
        '{OP_CMP,  MAX32, 32'sd1, 0, '{0, 0, 0, 0, 0}},
        '{OP_LOAD, MAX32, 32'sd1, 0, '{0, 0, 0, 0, 0}},
        '{OP_INC,  32'sd0, 32'sd0, 0, '{0, 0, 0, 0, 0}},
        '{OP_ADD,  32'sd0, 32'sd0, 0, '{0, 0, 0, 0, 0}},
        '{OP_INC,  32'sd0, 32'sd0, 0, '{0, 0, 0, 0, 0}},
        '{OP_LOAD, 32'sd1, MIN32, 0, '{0, 0, 0, 0, 0}},
        '{OP_SUB,  32'sd1, -32'sd3, 0, '{0, 0, 0, 0, 0}},
        '{OP_CMP,  -32'sd1, MIN32, 0, '{0, 0, 0, 0, 0}},
        '{3'd5,    32'sd9, 32'sd9, 0, '{0, 0, 0, 0, 0}},
        '{3'd7,    -32'sd1, -32'sd1, 0, '{0, 0, 0, 0, 0}}
    };

    initial
    begin
        logic [2:0] op;
        int         n;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.operand_num <= '0;
        in_ch.operand_den <= '0;
        rst_n             <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the typed-in word rides along with its row.
        foreach (dir_rows[i])
        begin
            drv_chk <= dir_rows[i].chk;
            drv_res <= dir_rows[i].res;
            drv_row <= i;
            send_word(dir_rows[i].op, dir_rows[i].c, dir_rows[i].d);
        end
        drv_chk <= 1'b0;

        // Random part in four idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
                default: begin src_idle_pct = 10; snk_stall_pct = 10; end
            endcase
            for (n = 0; n < 370; n++)
            begin
                // Mostly a defined opcode, now and then an undefined one (5 to 7).
                op = $urandom_range(0, 99) < 3 ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
                send_word(op, rand_operand(), rand_operand());
            end
            // Hold off until every expected word has come.
            in_ch.valid <= 1'b0;
            while (result_count < sent_count)
                @(posedge clk);
        end

        while (result_count < sent_count)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("tb: %0d words sent, %0d result words checked over four idling phases",
                 sent_count, result_count);
        $display("tb: opcodes load %0d add %0d sub %0d inc %0d cmp %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

/* sim.f */
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_div.sv
sv/rational_accumulator_unit_core.sv
tb/tb.sv
